// ===== rtl/core/hrpe_pkg.sv =====
// Shared types and constants for the HTTPS/SVCB record param extractor.
// No dependencies; used by hrpe_parser and https_record_param_extractor.

package hrpe_pkg;

    localparam logic [15:0] TARGET_KEY_RESET = 16'd5;      // ech config list
    localparam logic [7:0]  LABEL_TYPE_MASK  = 8'hC0;

    typedef enum logic [1:0] {
        STATUS_STREAM    = 2'd0,
        STATUS_FOUND     = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_MALFORMED = 2'd3
    } status_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] value_byte;
        logic       byte_valid;
        logic       final_res;
        status_t    status;
    } result_t;

endpackage

// ===== rtl/core/hrpe_parser.sv =====
// Byte-wise SVCB rdata walker: priority, target name, SvcParams.
// Depends on hrpe_pkg; instantiated by https_record_param_extractor.

module hrpe_parser
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_en,
    input  logic [7:0]        data_byte,
    input  logic              end_of_record,
    input  logic [15:0]       target_key,
    output hrpe_pkg::result_t result
);

    typedef enum logic [3:0] {
        PH_PRI_HI,
        PH_PRI_LO,
        PH_NAME_LEN,
        PH_LABEL,
        PH_PTR,
        PH_KEY_HI,
        PH_KEY_LO,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_STREAM,
        PH_SKIP
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [15:0] param_key_reg, param_key_next;
    logic [7:0]  length_high_reg, length_high_next;
    logic        done_reg, done_next;

    logic        finished_now;
    logic        last_count;
    logic [15:0] len;
    logic [7:0]  label_type;

    assign last_count = (bytes_left_reg <= 16'd1);
    assign len        = {length_high_reg, data_byte};
    assign label_type = data_byte & hrpe_pkg::LABEL_TYPE_MASK;

    always_comb
    begin
        phase_next       = phase_reg;
        bytes_left_next  = bytes_left_reg;
        param_key_next   = param_key_reg;
        length_high_next = length_high_reg;
        done_next        = done_reg;
        finished_now     = 1'b0;
        result           = '0;

        if (!done_reg)
        begin
            case (phase_reg)
                PH_PRI_HI: phase_next = PH_PRI_LO;
                PH_PRI_LO: phase_next = PH_NAME_LEN;
                PH_NAME_LEN:
                begin
                    if (data_byte == 8'd0)
                    begin
                        phase_next = PH_KEY_HI;
                    end
                    else if (label_type == hrpe_pkg::LABEL_TYPE_MASK)
                    begin
                        phase_next = PH_PTR;
                    end
                    else if (label_type != 8'd0)
                    begin
                        result.valid     = 1'b1;
                        result.final_res = 1'b1;
                        result.status    = hrpe_pkg::STATUS_MALFORMED;
                        finished_now     = 1'b1;
                    end
                    else
                    begin
                        bytes_left_next = {8'd0, data_byte};
                        phase_next      = PH_LABEL;
                    end
                end
                PH_LABEL:
                begin
                    if (last_count)
                    begin
                        bytes_left_next = '0;
                        phase_next      = PH_NAME_LEN;
                    end
                    else
                    begin
                        bytes_left_next = bytes_left_reg - 16'd1;
                    end
                end
                PH_PTR: phase_next = PH_KEY_HI;
                PH_KEY_HI:
                begin
                    param_key_next = {data_byte, 8'd0};
                    phase_next     = PH_KEY_LO;
                end
                PH_KEY_LO:
                begin
                    param_key_next = {param_key_reg[15:8], data_byte};
                    phase_next     = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    length_high_next = data_byte;
                    phase_next       = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    if (param_key_reg == target_key)
                    begin
                        if (len == 16'd0)
                        begin
                            result.valid     = 1'b1;
                            result.final_res = 1'b1;
                            result.status    = hrpe_pkg::STATUS_FOUND;
                            finished_now     = 1'b1;
                        end
                        else
                        begin
                            bytes_left_next = len;
                            phase_next      = PH_STREAM;
                        end
                    end
                    else if (len == 16'd0)
                    begin
                        phase_next = PH_KEY_HI;
                    end
                    else
                    begin
                        bytes_left_next = len;
                        phase_next      = PH_SKIP;
                    end
                end
                PH_STREAM:
                begin
                    result.valid      = 1'b1;
                    result.value_byte = data_byte;
                    result.byte_valid = 1'b1;
                    if (last_count)
                    begin
                        bytes_left_next  = '0;
                        result.final_res = 1'b1;
                        result.status    = hrpe_pkg::STATUS_FOUND;
                        finished_now     = 1'b1;
                    end
                    else
                    begin
                        bytes_left_next = bytes_left_reg - 16'd1;
                    end
                end
                PH_SKIP:
                begin
                    if (last_count)
                    begin
                        bytes_left_next = '0;
                        phase_next      = PH_KEY_HI;
                    end
                    else
                    begin
                        bytes_left_next = bytes_left_reg - 16'd1;
                    end
                end
                default: phase_next = PH_PRI_HI;
            endcase
            if (finished_now)
            begin
                done_next = 1'b1;
            end
        end

        if (end_of_record)
        begin
            if (!done_reg && !finished_now)
            begin
                result.valid     = 1'b1;
                result.final_res = 1'b1;
                // end at a param boundary or inside a param header
                if (phase_next == PH_KEY_HI || phase_next == PH_KEY_LO ||
                    phase_next == PH_LEN_HI || phase_next == PH_LEN_LO)
                begin
                    result.status = hrpe_pkg::STATUS_NOT_FOUND;
                end
                else
                begin
                    result.status = hrpe_pkg::STATUS_MALFORMED;
                end
            end
            phase_next       = PH_PRI_HI;
            bytes_left_next  = '0;
            param_key_next   = '0;
            length_high_next = '0;
            done_next        = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_PRI_HI;
            bytes_left_reg  <= '0;
            param_key_reg   <= '0;
            length_high_reg <= '0;
            done_reg        <= 1'b0;
        end
        else if (byte_en)
        begin
            phase_reg       <= phase_next;
            bytes_left_reg  <= bytes_left_next;
            param_key_reg   <= param_key_next;
            length_high_reg <= length_high_next;
            done_reg        <= done_next;
        end
    end

endmodule

// ===== rtl/core/https_record_param_extractor.sv =====
// Top level of the HTTPS/SVCB record param extractor: stream ports,
// key register and output register. Depends on hrpe_pkg and hrpe_parser.

// Takes DNS HTTPS/SVCB rdata one byte per transfer (tlast on the record's
// last byte) and streams out the value bytes of the first SvcParam whose key
// equals target_key (reset 5, ech config list), ending every record with one
// transfer whose tlast is set and whose status tells found, not found or
// malformed. One byte is taken every cycle: the parser state updates in the
// cycle the byte arrives and the result sits in one output register, so the
// input stalls only while that register holds a result the sink has not taken.

module https_record_param_extractor
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,      // target_key
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,     // [7:0] data_byte
    input  logic        s_axis_tlast,     // end_of_record
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,     // [7:0] value_byte
    output logic        m_axis_tlast,     // final_res
    output logic [2:0]  m_axis_tuser      // [0] byte_valid, [2:1] status
);

    logic              [15:0] target_key_reg;
    logic                     accept;
    hrpe_pkg::result_t        result;
    hrpe_pkg::result_t        out_reg;

    assign s_axis_tready = !out_reg.valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_key_reg <= hrpe_pkg::TARGET_KEY_RESET;
        end
        else if (cfg_wr_en)
        begin
            target_key_reg <= cfg_wr_data;
        end
    end

    hrpe_parser u_parser
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_en       (accept),
        .data_byte     (s_axis_tdata),
        .end_of_record (s_axis_tlast),
        .target_key    (target_key_reg),
        .result        (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else if (accept)
        begin
            out_reg <= result;
        end
        else if (m_axis_tready)
        begin
            out_reg.valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_reg.valid;
    assign m_axis_tdata  = out_reg.value_byte;
    assign m_axis_tlast  = out_reg.final_res;
    assign m_axis_tuser  = {out_reg.status, out_reg.byte_valid};

endmodule

// ===== dv/hrpe_tb_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard for the HTTPS/SVCB record param extractor testbench: tracks the
// record parse per accepted byte and checks outgoing transfers. Needs hrpe_pkg.

package hrpe_tb_pkg;

    typedef enum logic [3:0] {
        PS_PRI_HI,
        PS_PRI_LO,
        PS_NAME_LEN,
        PS_LABEL,
        PS_PTR,
        PS_KEY_HI,
        PS_KEY_LO,
        PS_LEN_HI,
        PS_LEN_LO,
        PS_STREAM,
        PS_SKIP
    } parse_step_t;

    typedef struct {
        logic [7:0]        value_byte;
        logic              byte_valid;
        logic              final_res;
        hrpe_pkg::status_t status;
    } extract_result_t;

    class param_extract_scoreboard;
        logic [15:0]     match_key;
        parse_step_t     step;
        logic [15:0]     bytes_left;
        logic [15:0]     param_key;
        logic [7:0]      length_high;
        bit              record_done;
        extract_result_t owed_results[$];
        int unsigned     failures;

        function new();
            match_key = hrpe_pkg::TARGET_KEY_RESET;
            failures  = 0;
            clear_record();
        endfunction

        function void clear_record();
            step        = PS_PRI_HI;
            bytes_left  = '0;
            param_key   = '0;
            length_high = '0;
            record_done = 1'b0;
        endfunction

        function void set_key(logic [15:0] key);
            match_key = key;
        endfunction

        function void note_rdata_byte(logic [7:0] b, logic last);
            extract_result_t r;
            bit              emit;
            bit              finished;
            bit              was_done;
            logic [15:0]     len;
            r.value_byte = '0;
            r.byte_valid = 1'b0;
            r.final_res  = 1'b0;
            r.status     = hrpe_pkg::STATUS_STREAM;
            emit         = 1'b0;
            finished     = 1'b0;
            was_done     = record_done;
            if (!was_done)
            begin
                case (step)
                    PS_PRI_HI: step = PS_PRI_LO;
                    PS_PRI_LO: step = PS_NAME_LEN;
                    PS_NAME_LEN:
                    begin
                        if (b == 8'h00)
                            step = PS_KEY_HI;
                        else if ((b & hrpe_pkg::LABEL_TYPE_MASK) == hrpe_pkg::LABEL_TYPE_MASK)
                            step = PS_PTR;
                        else if ((b & hrpe_pkg::LABEL_TYPE_MASK) != 8'h00)
                        begin
                            emit        = 1'b1;
                            r.final_res = 1'b1;
                            r.status    = hrpe_pkg::STATUS_MALFORMED;
                            finished    = 1'b1;
                        end
                        else
                        begin
                            bytes_left = {8'h00, b};
                            step       = PS_LABEL;
                        end
                    end
                    PS_LABEL:
                    begin
                        if (bytes_left <= 1)
                        begin
                            bytes_left = '0;
                            step       = PS_NAME_LEN;
                        end
                        else
                            bytes_left = bytes_left - 16'd1;
                    end
                    PS_PTR: step = PS_KEY_HI;
                    PS_KEY_HI:
                    begin
                        param_key = {b, 8'h00};
                        step      = PS_KEY_LO;
                    end
                    PS_KEY_LO:
                    begin
                        param_key[7:0] = b;
                        step           = PS_LEN_HI;
                    end
                    PS_LEN_HI:
                    begin
                        length_high = b;
                        step        = PS_LEN_LO;
                    end
                    PS_LEN_LO:
                    begin
                        len = {length_high, b};
                        if (param_key == match_key)
                        begin
                            if (len == 0)
                            begin
                                emit        = 1'b1;
                                r.final_res = 1'b1;
                                r.status    = hrpe_pkg::STATUS_FOUND;
                                finished    = 1'b1;
                            end
                            else
                            begin
                                bytes_left = len;
                                step       = PS_STREAM;
                            end
                        end
                        else if (len == 0)
                            step = PS_KEY_HI;
                        else
                        begin
                            bytes_left = len;
                            step       = PS_SKIP;
                        end
                    end
                    PS_STREAM:
                    begin
                        emit         = 1'b1;
                        r.value_byte = b;
                        r.byte_valid = 1'b1;
                        if (bytes_left <= 1)
                        begin
                            bytes_left  = '0;
                            r.final_res = 1'b1;
                            r.status    = hrpe_pkg::STATUS_FOUND;
                            finished    = 1'b1;
                        end
                        else
                            bytes_left = bytes_left - 16'd1;
                    end
                    PS_SKIP:
                    begin
                        if (bytes_left <= 1)
                        begin
                            bytes_left = '0;
                            step       = PS_KEY_HI;
                        end
                        else
                            bytes_left = bytes_left - 16'd1;
                    end
                    default: step = PS_PRI_HI;
                endcase
                if (finished)
                    record_done = 1'b1;
            end
            if (last)
            begin
                if (!was_done && !finished)
                begin
                    emit        = 1'b1;
                    r.final_res = 1'b1;
                    // record ended on a param boundary or in a param header
                    if (step == PS_KEY_HI || step == PS_KEY_LO ||
                        step == PS_LEN_HI || step == PS_LEN_LO)
                        r.status = hrpe_pkg::STATUS_NOT_FOUND;
                    else
                        r.status = hrpe_pkg::STATUS_MALFORMED;
                end
                clear_record();
            end
            if (emit)
                owed_results.insert(owed_results.size(), r);
        endfunction

        function void check_extract_result(logic [7:0] vbyte, logic fin, logic [2:0] user);
            extract_result_t   want;
            hrpe_pkg::status_t got_status;
            got_status = hrpe_pkg::status_t'(user[2:1]);
            if (owed_results.size() == 0)
            begin
                $error("unexpected transfer: value_byte %0h tlast %0b tuser %0h",
                       vbyte, fin, user);
                failures++;
                return;
            end
            want = owed_results.pop_front();
            if (vbyte !== want.value_byte)
            begin
                $error("value_byte: expected %0h, actual %0h", want.value_byte, vbyte);
                failures++;
            end
            if (user[0] !== want.byte_valid)
            begin
                $error("byte_valid: expected %0b, actual %0b", want.byte_valid, user[0]);
                failures++;
            end
            if (fin !== want.final_res)
            begin
                $error("final_res: expected %0b, actual %0b", want.final_res, fin);
                failures++;
            end
            if (got_status !== want.status)
            begin
                $error("status: expected %s, actual %0d", want.status.name(), user[2:1]);
                failures++;
            end
        endfunction
    endclass

endpackage

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the HTTPS/SVCB record param extractor testbench: clock, reset,
// stream drivers and monitor. Needs hrpe_pkg, hrpe_tb_pkg and the RTL.

module tb_top;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic [2:0]  m_axis_tuser;

    hrpe_tb_pkg::param_extract_scoreboard extract_sb = new();
    logic [7:0]  rec_bytes[$];
    bit          idle_on;
    bit          hold_req;
    int unsigned hold_left;

    https_record_param_extractor dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                extract_sb.note_rdata_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                extract_sb.check_extract_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end
    end

    // sink side: random stalls, plus one long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        hold_left     = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = 200;
            end
            if (!rst_n)
                m_axis_tready <= 1'b0;
            else if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= !idle_on || ($urandom_range(0, 99) >= 17);
        end
    end

    function automatic void add_byte(input logic [7:0] b);
        rec_bytes.insert(rec_bytes.size(), b);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (idle_on)
        begin
            while ($urandom_range(0, 99) < 17)
            begin
                s_axis_tvalid <= 1'b0;
                @(negedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic send_record();
        int unsigned i;
        for (i = 0; i < rec_bytes.size(); i++)
            send_byte(rec_bytes[i], i == rec_bytes.size() - 1);
    endtask

    task automatic build_random_record();
        int unsigned pick;
        int unsigned n_labels;
        int unsigned n_params;
        int unsigned lab_len;
        int unsigned val_len;
        int unsigned keep;
        int unsigned i;
        int unsigned j;
        logic [15:0] key;
        logic [15:0] plen;
        bit          cut_short;
        rec_bytes.delete();
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            // noise
            pick = $urandom_range(1, 12);
            for (i = 0; i < pick; i++)
                add_byte(8'($urandom_range(0, 255)));
            return;
        end
        add_byte(8'($urandom_range(0, 255)));
        add_byte(8'($urandom_range(0, 255)));
        n_labels = $urandom_range(0, 2);
        for (i = 0; i < n_labels; i++)
        begin
            lab_len = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 63)
                                                   : $urandom_range(1, 5);
            add_byte(8'(lab_len));
            for (j = 0; j < lab_len; j++)
                add_byte(8'($urandom_range(0, 255)));
        end
        pick = $urandom_range(0, 99);
        if (pick < 50)
            add_byte(8'h00);
        else if (pick < 85)
        begin
            add_byte({2'b11, 6'($urandom)});
            add_byte(8'($urandom_range(0, 255)));
        end
        else
            add_byte({(($urandom_range(0, 1) == 0) ? 2'b01 : 2'b10), 6'($urandom)});
        n_params  = $urandom_range(0, 4);
        cut_short = 1'b0;
        for (i = 0; i < n_params && !cut_short; i++)
        begin
            key = ($urandom_range(0, 2) == 0) ? extract_sb.match_key : 16'($urandom);
            if ($urandom_range(0, 19) == 0)
            begin
                plen      = 16'($urandom);
                val_len   = $urandom_range(0, 8);
                cut_short = 1'b1;
            end
            else
            begin
                plen    = ($urandom_range(0, 14) == 0) ? 16'($urandom_range(7, 40))
                                                       : 16'($urandom_range(0, 6));
                val_len = plen;
            end
            add_byte(key[15:8]);
            add_byte(key[7:0]);
            add_byte(plen[15:8]);
            add_byte(plen[7:0]);
            for (j = 0; j < val_len; j++)
                add_byte(8'($urandom_range(0, 255)));
        end
        if (!cut_short && $urandom_range(0, 99) < 20)
        begin
            pick = $urandom_range(1, 3);
            for (i = 0; i < pick; i++)
                add_byte(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 3) == 0)
        begin
            keep = $urandom_range(1, rec_bytes.size());
            while (rec_bytes.size() > keep)
                void'(rec_bytes.pop_back());
        end
    endtask

    task automatic run_random_phase(input int unsigned n_bytes);
        int unsigned sent;
        sent = 0;
        while (sent < n_bytes)
        begin
            build_random_record();
            send_record();
            sent += rec_bytes.size();
        end
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic write_key(input logic [15:0] key);
        while (extract_sb.owed_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= key;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        extract_sb.set_key(key);
    endtask

    initial
    begin
        int unsigned wait_cycles;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        idle_on       = 1'b1;
        hold_req      = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed, reset key: two value bytes then an ignored byte
        rec_bytes = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h05, 8'h00, 8'h02,
                      8'h00, 8'hFF, 8'h77};
        send_record();
        // pointer name, empty matched value
        rec_bytes = '{8'h00, 8'h00, 8'hC0, 8'hFF, 8'h00, 8'h05, 8'h00, 8'h00};
        send_record();
        // reserved label type
        rec_bytes = '{8'h00, 8'h00, 8'h80, 8'h55};
        send_record();
        // truncated priority
        rec_bytes = '{8'h00};
        send_record();
        // label, skipped param, end inside the next param header
        rec_bytes = '{8'h00, 8'h00, 8'h01, 8'h61, 8'h00, 8'h00, 8'h07,
                      8'h00, 8'h01, 8'hAA, 8'h00};
        send_record();
        s_axis_tvalid <= 1'b0;

        run_random_phase(100);
        write_key(16'h0000);
        run_random_phase(130);
        write_key(16'hFFFF);
        hold_req = 1'b1;
        run_random_phase(130);
        write_key(16'($urandom));
        idle_on = 1'b0;
        run_random_phase(130);
        idle_on = 1'b1;
        write_key(hrpe_pkg::TARGET_KEY_RESET);
        run_random_phase(130);

        wait_cycles = 0;
        while (extract_sb.owed_results.size() != 0 && wait_cycles < 2000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        if (extract_sb.owed_results.size() != 0)
        begin
            $error("%0d expected transfers never arrived", extract_sb.owed_results.size());
            extract_sb.failures++;
        end
        repeat (10) @(posedge clk);
        if (extract_sb.failures == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
